/* rtl/dbcs_pkg.sv */
package dbcs_pkg;

    // Length counter width default
    localparam int LENGTH_BITS_DEF = 16;
    localparam int SHOW_BITS       = 16;

    // Output queue depth
    localparam int QUEUE_DEPTH = 4;

    // Register indexes
    localparam logic REG_LANGUAGE = 1'b0;

    // Language codes
    localparam logic [3:0] LANG_JAPANESE = 4'd8;
    localparam logic [3:0] LANG_KOREAN   = 4'd9;
    localparam logic [3:0] LANG_CHINESE  = 4'd10;
    localparam logic [3:0] LANG_THAI     = 4'd11;

    // Character kinds
    localparam logic [1:0] KIND_SINGLE = 2'd0;
    localparam logic [1:0] KIND_DOUBLE = 2'd1;
    localparam logic [1:0] KIND_ESCAPE = 2'd2;

    // Special bytes
    localparam logic [7:0] CHAR_CARET = 8'h5E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [15:0] char_code;
        logic [1:0]  char_kind;
        logic        trailing_punct;
        logic        counted;
        logic [15:0] printable_length;
        logic        string_end;
    } t_out_item;

    function automatic logic in_range(input logic [15:0] v, input logic [15:0] lo,
                                      input logic [15:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    // Lead/follow range test per language
    function automatic logic pair_ok(input logic [3:0] lang, input logic [7:0] lead,
                                     input logic [7:0] follow);
        logic [15:0] l;
        logic [15:0] f;
        logic        ok;
        l  = {8'h00, lead};
        f  = {8'h00, follow};
        ok = 1'b0;
        unique case (lang)
            LANG_JAPANESE: ok = (in_range(l, 16'hB0, 16'hC8) || in_range(l, 16'hE0, 16'hEF))
                                && in_range(f, 16'hA1, 16'hFE);
            LANG_KOREAN:   ok = (in_range(l, 16'hA1, 16'hC6) || in_range(l, 16'hC9, 16'hF9))
                                && (in_range(f, 16'h40, 16'h7E) || in_range(f, 16'hA1, 16'hFE));
            LANG_CHINESE:  ok = (in_range(l, 16'h81, 16'h9F) || in_range(l, 16'hE0, 16'hEF))
                                && (in_range(f, 16'h40, 16'h7E) || in_range(f, 16'h80, 16'hFC));
            LANG_THAI:     ok = in_range(l, 16'hA1, 16'hF7) && in_range(f, 16'hA1, 16'hFE);
            default:       ok = 1'b0;
        endcase
        return ok;
    endfunction

    // Trailing punctuation for a double-byte code
    function automatic logic double_punct(input logic [3:0] lang, input logic [15:0] code);
        logic p;
        p = 1'b0;
        unique case (lang)
            LANG_KOREAN:  p = in_range(code, 16'hA140, 16'hA153);
            LANG_CHINESE: p = in_range(code, 16'h8140, 16'h8151);
            LANG_THAI:    p = in_range(code, 16'hA1A1, 16'hA1AD);
            default:      p = 1'b0;
        endcase
        return p;
    endfunction

    // Trailing punctuation for a single byte: ! ? , . ; :
    function automatic logic single_punct(input logic [7:0] b);
        return (b == 8'h21) || (b == 8'h3F) || (b == 8'h2C) || (b == 8'h2E) ||
               (b == 8'h3B) || (b == 8'h3A);
    endfunction

endpackage

/* rtl/dbcs_decode.sv */
module dbcs_decode
    import dbcs_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  t_in_item    i_item,
    input  logic [3:0]  i_language,
    output t_out_item   o_res0,
    output t_out_item   o_res1,
    output logic [1:0]  o_res_cnt
);

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    logic [7:0]             r_held_byte;
    logic [7:0]             n_held_byte;
    logic                   r_held_valid;
    logic                   n_held_valid;
    logic [LENGTH_BITS-1:0] r_len;
    logic [LENGTH_BITS-1:0] n_len;

    logic [LENGTH_BITS-1:0] len0;
    logic [LENGTH_BITS-1:0] len1;
    logic                   is_pair;
    logic                   is_escape;
    logic [15:0]            pair_code;

    // Add one unless saturated
    function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] v,
                                                       input logic c);
        return (c && (v != LEN_MAX)) ? v + 1'b1 : v;
    endfunction

    // Cap the counter at the shown width
    function automatic logic [SHOW_BITS-1:0] shown(input logic [LENGTH_BITS-1:0] v);
        logic [LENGTH_BITS+SHOW_BITS-1:0] ext;
        ext = {{SHOW_BITS{1'b0}}, v};
        return (ext > {{LENGTH_BITS{1'b0}}, {SHOW_BITS{1'b1}}}) ? {SHOW_BITS{1'b1}}
                                                                  : ext[SHOW_BITS-1:0];
    endfunction

    function automatic t_out_item single_item(input logic [7:0] b, input logic e);
        t_out_item it;
        it.char_code        = {8'h00, b};
        it.char_kind        = KIND_SINGLE;
        it.trailing_punct   = single_punct(b);
        it.counted          = !((b == CHAR_LF) || (b == CHAR_CR));
        it.printable_length = '0;
        it.string_end       = e;
        return it;
    endfunction

    assign pair_code = {r_held_byte, i_item.text_byte};
    assign is_pair   = pair_ok(i_language, r_held_byte, i_item.text_byte);
    assign is_escape = (r_held_byte == CHAR_CARET) && (i_item.text_byte >= CHAR_ZERO)
                       && (i_item.text_byte <= CHAR_NINE);

    // Form up to two characters and advance the lookahead and length
    always_comb begin
        n_held_byte  = r_held_byte;
        n_held_valid = r_held_valid;
        o_res0       = single_item(i_item.text_byte, i_item.final_byte);
        o_res1       = single_item(i_item.text_byte, 1'b1);
        o_res_cnt    = 2'd0;
        if (i_accept) begin
            if (r_held_valid) begin
                n_held_valid = 1'b0;
                if (is_pair) begin
                    o_res0.char_code      = pair_code;
                    o_res0.char_kind      = KIND_DOUBLE;
                    o_res0.trailing_punct = double_punct(i_language, pair_code);
                    o_res0.counted        = 1'b1;
                    o_res_cnt             = 2'd1;
                end else if (is_escape) begin
                    o_res0.char_code      = pair_code;
                    o_res0.char_kind      = KIND_ESCAPE;
                    o_res0.trailing_punct = 1'b0;
                    o_res0.counted        = 1'b0;
                    o_res_cnt             = 2'd1;
                end else begin
                    o_res0 = single_item(r_held_byte, 1'b0);
                    if (i_item.final_byte) begin
                        o_res_cnt = 2'd2;
                    end else begin
                        o_res_cnt    = 2'd1;
                        n_held_byte  = i_item.text_byte;
                        n_held_valid = 1'b1;
                    end
                end
            end else begin
                if (i_item.final_byte) begin
                    o_res_cnt = 2'd1;
                end else begin
                    n_held_byte  = i_item.text_byte;
                    n_held_valid = 1'b1;
                end
            end
        end

        // Running length, cleared after the last character of a string
        len0 = sat_inc(r_len, o_res_cnt != 2'd0 && o_res0.counted);
        len1 = sat_inc(len0, o_res_cnt == 2'd2 && o_res1.counted);
        o_res0.printable_length = shown(len0);
        o_res1.printable_length = shown(len1);
        n_len = len1;
        if ((o_res_cnt != 2'd0) && (o_res0.string_end || o_res_cnt == 2'd2)) begin
            n_len        = '0;
            n_held_byte  = '0;
            n_held_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_byte  <= '0;
            r_held_valid <= 1'b0;
            r_len        <= '0;
        end else begin
            r_held_byte  <= n_held_byte;
            r_held_valid <= n_held_valid;
            r_len        <= n_len;
        end
    end

endmodule

/* rtl/dbcs_out_queue.sv */
module dbcs_out_queue
    import dbcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_out_item   i_res0,
    input  t_out_item   i_res1,
    input  logic [1:0]  i_res_cnt,
    output logic        o_room,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_item
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    t_out_item             r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   r_wr_ptr;
    logic [PTR_BITS-1:0]   n_wr_ptr;
    logic [PTR_BITS-1:0]   r_rd_ptr;
    logic [PTR_BITS-1:0]   n_rd_ptr;
    logic [CNT_BITS-1:0]   r_count;
    logic [CNT_BITS-1:0]   n_count;
    logic [PTR_BITS-1:0]   wr_ptr1;
    logic                  pop;

    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign pop     = o_valid && !i_stall;
    // Accept only with room for two characters
    assign o_room  = (r_count <= CNT_BITS'(QUEUE_DEPTH - 2));
    assign wr_ptr1 = r_wr_ptr + 1'b1;

    // Advance pointers and fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_BITS'(i_res_cnt);
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + CNT_BITS'(i_res_cnt) - CNT_BITS'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the new characters
    always_ff @(posedge i_clk) begin
        if (i_res_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_res_cnt == 2'd2) begin
            r_mem[wr_ptr1] <= i_res1;
        end
    end

endmodule

/* rtl/dbcs_char_decoder_length_counter.sv */
// Double-byte character decoder with printable-length counter. Feed the string one byte per
// transaction with final_byte set on its last byte; for languages 8 to 11 a lead byte is held
// one byte and joined with its follow byte into one 16-bit character, otherwise bytes come out
// singly, and a caret before a digit comes out as an uncounted color escape. Each character
// carries the running printable length (saturating) and the last one of a string carries
// string_end. The block takes one byte per cycle; a byte gives zero, one or two characters,
// which go through a four-entry output queue delivering one character per cycle unless
// i_out_stall holds it, so input stalls only while that queue holds more than two characters.
// Write the language register over the APB port only while the block is idle.
module dbcs_char_decoder_length_counter
    import dbcs_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [3:0]  r_language;
    logic        room;
    logic        accept;
    t_out_item   res0;
    t_out_item   res1;
    logic [1:0]  res_cnt;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LANGUAGE) ? {28'h0, r_language} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_language <= 4'd0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_LANGUAGE)) begin
            r_language <= pwdata[3:0];
        end
    end

    assign o_in_stall = !room;
    assign accept     = i_in_valid && room;

    dbcs_decode #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_in_item),
        .i_language (r_language),
        .o_res0     (res0),
        .o_res1     (res1),
        .o_res_cnt  (res_cnt)
    );

    dbcs_out_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_res0    (res0),
        .i_res1    (res1),
        .i_res_cnt (res_cnt),
        .o_room    (room),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_item    (o_out_item)
    );

endmodule

/* rtl/dbcs_checker.sv */
module dbcs_checker
    import dbcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  t_out_item   o_out_item
);

    // No character right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // A stalled character holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled output changed");

    // Kind code three is never produced
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.char_kind != 2'd3)
        else $error("illegal char_kind");

    // Color escapes are uncounted, not punctuation, and start with a caret
    a_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.char_kind == KIND_ESCAPE |->
            !o_out_item.counted && !o_out_item.trailing_punct &&
            o_out_item.char_code[15:8] == CHAR_CARET)
        else $error("bad color escape");

    // Length grows by at most one within a string
    a_len_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_item.string_end ##1 o_out_valid |->
            o_out_item.printable_length - $past(o_out_item.printable_length) <= 16'd1)
        else $error("length jumped");

endmodule

bind dbcs_char_decoder_length_counter dbcs_checker u_dbcs_checker (.*);
